// ----- rtl/npic_pkg.sv -----
// ============================================================================
// npic_pkg
// Shared types and constants of the nested priority interrupt controller.
// ============================================================================
package npic_pkg;

    localparam int PRIO_COUNT = 32;           // priority bytes, one per device line slot
    localparam int PRIO_W     = 8;
    localparam int NIB_W      = 4;            // ranking bits of a priority byte
    localparam int PIDX_W     = 5;            // index into the priority bytes
    localparam int LINE_W     = 6;
    localparam int WORD_W     = 32;

    localparam logic [4:0]        CTRL_WORD_IDX = 5'd8;
    localparam int                CTRL_GMASK_BIT = 31;
    localparam int                CTRL_NEST_BIT  = 7;
    localparam logic [WORD_W-1:0] CTRL_RESET     = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_WORD_WR = 3'd0,
        CMD_WORD_RD = 3'd1,
        CMD_BYTE_WR = 3'd2,
        CMD_BYTE_RD = 3'd3,
        CMD_RAISE   = 3'd4,
        CMD_CLAIM   = 3'd5,
        CMD_RETURN  = 3'd6
    } t_cmd;

    typedef logic [NIB_W-1:0] t_nib;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [4:0]        reg_addr;
        logic [WORD_W-1:0] bit_mask;
        logic [WORD_W-1:0] write_data;
        logic [LINE_W-1:0] line;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              claim_valid;
        logic [LINE_W-1:0] claimed_line;
        logic              return_error;
    } t_out_item;

    // winner of the device line search
    typedef struct packed {
        logic              found;
        logic [PIDX_W-1:0] idx;
        t_nib              prio;
    } t_pick;

endpackage

// ----- rtl/npic_ram.sv -----
// ============================================================================
// npic_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module npic_ram #(
    parameter int  WIDTH = 4,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/npic_pick.sv -----
// ============================================================================
// npic_pick
// Balanced compare tree over the pending device lines: lowest priority
// nibble wins, ties go to the lower line index.
// ============================================================================
module npic_pick import npic_pkg::*; (
    input  logic [PRIO_COUNT-1:0] i_pending,
    input  t_nib                  i_prio [PRIO_COUNT],
    output t_pick                 o_pick
);

    localparam int NODES = 2 * PRIO_COUNT - 1;

    // heap layout: node n has children 2n+1 (lower lines) and 2n+2
    t_pick node [NODES];

    for (genvar i = 0; i < PRIO_COUNT; i++) begin : g_leaf
        assign node[PRIO_COUNT-1+i] = '{found: i_pending[i],
                                        idx:   PIDX_W'(i),
                                        prio:  i_prio[i]};
    end

    for (genvar n = 0; n < PRIO_COUNT - 1; n++) begin : g_node
        // right side wins only when strictly better
        assign node[n] = (node[2*n+2].found &&
                          (!node[2*n+1].found || (node[2*n+2].prio < node[2*n+1].prio)))
                         ? node[2*n+2] : node[2*n+1];
    end

    assign o_pick = node[0];

endmodule

// ----- rtl/nested_priority_interrupt_controller_core.sv -----
// ============================================================================
// nested_priority_interrupt_controller_core
// Nested priority interrupt controller: register access, line raising,
// claim arbitration and a stack of active priorities.
// ============================================================================
// Each command item passes the input register, then one pass of logic into
// the result register. Throughput is one item per cycle for every command
// mix while the result side does not stall; the path that sets the clock is
// the 32-way priority compare tree feeding the claim decision. An item may
// be accepted while the previous result still waits: the input register and
// the result register decouple the two channels. The stack of active
// priorities lives in a RAM (STACK_DEPTH entries of 4 bits) with a
// registered read; the top entry is mirrored in a register and the RAM
// keeps the entry just below the top prefetched, so a return restores the
// new top without a bubble. Stack entries are never cleared: only pushed
// entries are used, so there is no clearing pass after reset.
// ============================================================================
module nested_priority_interrupt_controller_core import npic_pkg::*; #(
    parameter int DEVICE_LINES   = 32,
    parameter int INTERNAL_LINES = 8,
    parameter int STACK_DEPTH    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int DW = $clog2(STACK_DEPTH + 1);   // depth counter holds 0..STACK_DEPTH
    localparam int AW = $clog2(STACK_DEPTH);       // stack RAM address

    // ---------------------------------------------------------------- pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic advance;     // stage 2 item moves into the result register
    logic in_take;     // new item accepted into the input register

    // ---------------------------------------------------------------- state
    logic [PRIO_W-1:0]         r_prio [PRIO_COUNT];
    logic [PRIO_W-1:0]         n_prio [PRIO_COUNT];
    logic [WORD_W-1:0]         r_ctrl, n_ctrl;
    logic [DEVICE_LINES-1:0]   r_dev_pend, n_dev_pend;
    logic [INTERNAL_LINES-1:0] r_int_pend, n_int_pend;
    logic [DW-1:0]             r_depth, n_depth;
    t_nib                      r_top, n_top;   // copy of stack[depth-1]

    // ---------------------------------------------------------------- helpers
    t_cmd              cmd;
    logic [4:0]        addr;
    logic [2:0]        word_idx;
    logic [WORD_W-1:0] prio_word;
    logic [WORD_W-1:0] word_get;
    logic [WORD_W-1:0] merged;
    t_nib              prio_nib [PRIO_COUNT];
    logic [DEVICE_LINES-1:0]   nz_mask;
    logic [INTERNAL_LINES-1:0] int_iso;
    logic [LINE_W-1:0]         int_idx;
    logic [LINE_W-1:0]         int_line;
    t_pick             pick;
    logic              dev_ok;
    logic              claim_gate;
    logic              push;
    t_nib              push_val;
    t_nib              stk_below;      // stack[depth-2], prefetched

    // handshake: stall only when the input register holds an item that cannot move
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // device arbitration
    always_comb begin
        for (int i = 0; i < PRIO_COUNT; i++) begin
            prio_nib[i] = r_prio[i][NIB_W-1:0];
        end
    end

    npic_pick u_pick (
        .i_pending (PRIO_COUNT'(r_dev_pend)),
        .i_prio    (prio_nib),
        .o_pick    (pick)
    );

    // lowest pending internal line: isolate lowest set bit, then encode
    always_comb begin
        int_iso = r_int_pend & (~r_int_pend + INTERNAL_LINES'(1));
        int_idx = '0;
        for (int k = 0; k < INTERNAL_LINES; k++) begin
            if (int_iso[k]) begin
                int_idx = int_idx | LINE_W'(k);
            end
        end
        int_line = LINE_W'(DEVICE_LINES) + int_idx;
    end

    // lines dropped when the global mask gets set
    always_comb begin
        for (int i = 0; i < DEVICE_LINES; i++) begin
            nz_mask[i] = |prio_nib[i];
        end
    end

    // register file read: one word of four priority bytes or the control word, and the masked write merge
    always_comb begin
        cmd      = t_cmd'(r_in.cmd);
        addr     = r_in.reg_addr;
        word_idx = ((cmd == CMD_BYTE_WR) || (cmd == CMD_BYTE_RD)) ? addr[4:2] : addr[2:0];
        prio_word = {r_prio[{word_idx, 2'd3}], r_prio[{word_idx, 2'd2}],
                     r_prio[{word_idx, 2'd1}], r_prio[{word_idx, 2'd0}]};
        if (addr == CTRL_WORD_IDX) begin
            word_get = r_ctrl;
        end else if (addr < CTRL_WORD_IDX) begin
            word_get = prio_word;
        end else begin
            word_get = '0;
        end
        merged = (r_in.write_data & r_in.bit_mask) | (word_get & ~r_in.bit_mask);
    end

    // claim qualification
    assign dev_ok     = pick.found && ((r_depth == '0) || (pick.prio < r_top));
    assign claim_gate = ((r_ctrl[CTRL_NEST_BIT] && (r_depth <= DW'(r_ctrl[NIB_W-1:0])))
                         || (r_depth == '0) || (|r_int_pend))
                        && (r_depth != DW'(STACK_DEPTH));

    // command execution
    always_comb begin
        n_prio     = r_prio;
        n_ctrl     = r_ctrl;
        n_dev_pend = r_dev_pend;
        n_int_pend = r_int_pend;
        n_depth    = r_depth;
        n_top      = r_top;
        n_out      = '0;
        push       = 1'b0;
        push_val   = '0;

        if (advance) begin
            case (cmd)
                CMD_WORD_WR: begin
                    if (addr == CTRL_WORD_IDX) begin
                        n_ctrl = merged;
                        if (merged[CTRL_GMASK_BIT]) begin
                            n_dev_pend = r_dev_pend & ~nz_mask;
                        end
                    end else if (addr < CTRL_WORD_IDX) begin
                        for (int b = 0; b < 4; b++) begin
                            n_prio[{addr[2:0], 2'(b)}] = merged[8*b +: 8];
                        end
                    end
                end
                CMD_WORD_RD: begin
                    n_out.read_data = word_get & r_in.bit_mask;
                end
                CMD_BYTE_WR: begin
                    n_prio[addr] = r_in.write_data[PRIO_W-1:0];
                end
                CMD_BYTE_RD: begin
                    n_out.read_data = WORD_W'(prio_word[{addr[1:0], 3'b000} +: PRIO_W]);
                end
                CMD_RAISE: begin
                    for (int i = 0; i < DEVICE_LINES; i++) begin
                        if ((r_in.line == LINE_W'(i)) &&
                            (!r_ctrl[CTRL_GMASK_BIT] || (prio_nib[i] == '0))) begin
                            n_dev_pend[i] = 1'b1;
                        end
                    end
                    for (int k = 0; k < INTERNAL_LINES; k++) begin
                        if (r_in.line == LINE_W'(DEVICE_LINES + k)) begin
                            n_int_pend[k] = 1'b1;
                        end
                    end
                end
                CMD_CLAIM: begin
                    if (claim_gate) begin
                        if (|r_int_pend) begin
                            n_int_pend         = r_int_pend & ~int_iso;
                            push               = 1'b1;
                            push_val           = '0;
                            n_out.claim_valid  = 1'b1;
                            n_out.claimed_line = int_line;
                        end else if (dev_ok) begin
                            for (int i = 0; i < DEVICE_LINES; i++) begin
                                if (pick.idx == PIDX_W'(i)) begin
                                    n_dev_pend[i] = 1'b0;
                                end
                            end
                            push               = 1'b1;
                            push_val           = pick.prio;
                            n_out.claim_valid  = 1'b1;
                            n_out.claimed_line = LINE_W'(pick.idx);
                        end
                    end
                    if (push) begin
                        n_depth = r_depth + DW'(1);
                        n_top   = push_val;
                    end
                end
                CMD_RETURN: begin
                    if (r_depth == '0) begin
                        n_out.return_error = 1'b1;
                    end else begin
                        n_depth = r_depth - DW'(1);
                        n_top   = stk_below;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // stack body; read address tracks next depth - 2 so the entry below the
    // top is ready in the next cycle (never the entry written this cycle)
    npic_ram #(
        .WIDTH (NIB_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (push_val),
        .i_raddr (AW'(n_depth - DW'(2))),
        .o_rdata (stk_below)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PRIO_COUNT; i++) begin
                r_prio[i] <= PRIO_W'(i);
            end
            r_ctrl     <= CTRL_RESET;
            r_dev_pend <= '0;
            r_int_pend <= '0;
            r_depth    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_prio     <= n_prio;
            r_ctrl     <= n_ctrl;
            r_dev_pend <= n_dev_pend;
            r_int_pend <= n_int_pend;
            r_depth    <= n_depth;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
        r_top <= n_top;
    end

endmodule

// ----- rtl/npic_checker.sv -----
// ============================================================================
// npic_checker
// Port level checks of the interrupt controller core, bound to the core module.
// ============================================================================
module npic_checker import npic_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // input side never blocks while the result register is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // a line number only accompanies a grant
    a_line_with_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.claim_valid |-> o_out_item.claimed_line == '0)
        else $error("claimed line without grant");

endmodule

bind nested_priority_interrupt_controller_core npic_checker u_npic_checker (.*);
